FILE: rtl/nmea_rmc_speed_extractor_assert.svh
// ---------------------------------------------------------------------------
// NMEA RMC speed extractor assertion macros
// Shorthand for clocked assertions; clk and rst_n come from the using scope.
// ---------------------------------------------------------------------------
`ifndef NMEA_RMC_SPEED_EXTRACTOR_ASSERT_SVH
`define NMEA_RMC_SPEED_EXTRACTOR_ASSERT_SVH

// consequent checked in the same cycle
`define NRMC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define NRMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nrmc_pkg.sv
// ---------------------------------------------------------------------------
// NMEA RMC speed extractor package
// Widths, character codes, field numbers and shared types.
// ---------------------------------------------------------------------------
package nrmc_pkg;

    localparam int BYTE_W  = 8;
    localparam int KNOTS_W = 20;
    localparam int SCALE_W = 17;
    localparam int SPEED_W = 21;
    localparam int PROD_W  = KNOTS_W + SCALE_W;
    localparam int FIELD_W = 4;
    localparam int HDR_W   = 3;

    localparam int FRACTION_DIGITS = 3;
    localparam logic [1:0] FRAC_LIMIT =
        (FRACTION_DIGITS > 3) ? 2'd3 : 2'(FRACTION_DIGITS);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(75417);
    localparam logic [KNOTS_W-1:0] KNOTS_MAX   = KNOTS_W'(999999);
    localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(32768);
    localparam int                 FRAC_SHIFT  = 16;

    localparam logic [FIELD_W-1:0] STATUS_FIELD = 4'd2;
    localparam logic [FIELD_W-1:0] SPEED_FIELD  = 4'd7;
    localparam logic [FIELD_W-1:0] FIELD_MAX    = 4'd15;
    localparam logic [FIELD_W-1:0] FIELD_FIRST  = 4'd1;
    localparam logic [HDR_W-1:0]   HDR_LAST     = 3'd6;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_V      = 8'h56;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_C      = 8'h43;

    typedef struct packed {
        logic [KNOTS_W-1:0] knots_milli;
        logic               no_fix;
    } nrmc_event_t;

    // expected character at each position of "$GPRMC,"
    function automatic logic [BYTE_W-1:0] hdr_char(input logic [HDR_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = CH_G;
            3'd2:    c = CH_P;
            3'd3:    c = CH_R;
            3'd4:    c = CH_M;
            3'd5:    c = CH_C;
            3'd6:    c = CH_COMMA;
            default: c = '0;
        endcase
        return c;
    endfunction

    // place value of a fraction digit in thousandths
    function automatic logic [6:0] frac_weight(input logic [1:0] pos);
        logic [6:0] w;
        unique case (pos)
            2'd0:    w = 7'd100;
            2'd1:    w = 7'd10;
            2'd2:    w = 7'd1;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/nrmc_ifs.sv
// ---------------------------------------------------------------------------
// NMEA RMC speed extractor channels
// Valid/ready channels for received bytes and for speed results.
// ---------------------------------------------------------------------------
interface nrmc_byte_if;
    logic                         valid;
    logic                         ready;
    logic [nrmc_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_speed_if;
    logic                         valid;
    logic                         ready;
    logic [nrmc_pkg::SPEED_W-1:0] speed_milli_mph;
    logic                         fix_status;

    modport source (output valid, output speed_milli_mph, output fix_status, input ready);
    modport sink   (input valid, input speed_milli_mph, input fix_status, output ready);
endinterface

FILE: rtl/nrmc_parser.sv
// ---------------------------------------------------------------------------
// NMEA RMC byte parser
// Header match, field counting, status and speed accumulation; one byte per
// cycle unless stalled. A '*' inside a sentence loads the event register.
// ---------------------------------------------------------------------------
module nrmc_parser
#(
    parameter int FRACTION_DIGITS = nrmc_pkg::FRACTION_DIGITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    nrmc_byte_if.sink             rx,
    output logic                  ev_valid,
    output nrmc_pkg::nrmc_event_t ev,
    input  logic                  ev_ready
);

    localparam logic [1:0] FRAC_LIMIT =
        (FRACTION_DIGITS > 3) ? 2'd3 : 2'(FRACTION_DIGITS);

    logic [nrmc_pkg::HDR_W-1:0]   header_index_reg, header_index_next;
    logic                         in_sentence_reg, in_sentence_next;
    logic [nrmc_pkg::FIELD_W-1:0] field_count_reg, field_count_next;
    logic                         status_valid_reg, status_valid_next;
    logic [nrmc_pkg::KNOTS_W-1:0] knots_milli_reg, knots_milli_next;
    logic [1:0]                   fraction_digits_reg, fraction_digits_next;
    logic                         seen_point_reg, seen_point_next;
    logic                         ev_valid_reg, ev_valid_next;
    nrmc_pkg::nrmc_event_t        ev_reg, ev_next;

    logic                         accept;
    logic                         fire;
    logic [nrmc_pkg::BYTE_W-1:0]  b;
    logic                         is_digit;
    logic [3:0]                   digit;
    logic [23:0]                  int_sum;
    logic [10:0]                  frac_term;
    logic [20:0]                  frac_sum;

    assign b        = rx.rx_byte;
    assign rx.ready = !ev_valid_reg || ev_ready;
    assign accept   = rx.valid && rx.ready;
    assign is_digit = (b >= nrmc_pkg::CH_ZERO) && (b <= nrmc_pkg::CH_NINE);
    assign digit    = 4'(b - nrmc_pkg::CH_ZERO);
    assign int_sum  = {4'b0, knots_milli_reg} * 24'd10 + {20'b0, digit} * 24'd1000;
    assign frac_term = {7'b0, digit} * {4'b0, nrmc_pkg::frac_weight(fraction_digits_reg)};
    assign frac_sum  = {1'b0, knots_milli_reg} + {10'b0, frac_term};

    always_comb
    begin
        header_index_next    = header_index_reg;
        in_sentence_next     = in_sentence_reg;
        field_count_next     = field_count_reg;
        status_valid_next    = status_valid_reg;
        knots_milli_next     = knots_milli_reg;
        fraction_digits_next = fraction_digits_reg;
        seen_point_next      = seen_point_reg;
        fire                 = 1'b0;

        if (accept) begin
            if (b == nrmc_pkg::CH_DOLLAR) begin
                in_sentence_next  = 1'b0;
                header_index_next = 3'd1;
            end else if (!in_sentence_reg) begin
                if (header_index_reg != 3'd0 && header_index_reg <= nrmc_pkg::HDR_LAST &&
                    b == nrmc_pkg::hdr_char(header_index_reg)) begin
                    if (header_index_reg == nrmc_pkg::HDR_LAST) begin
                        in_sentence_next     = 1'b1;
                        header_index_next    = 3'd0;
                        field_count_next     = nrmc_pkg::FIELD_FIRST;
                        status_valid_next    = 1'b0;
                        knots_milli_next     = '0;
                        fraction_digits_next = 2'd0;
                        seen_point_next      = 1'b0;
                    end else begin
                        header_index_next = header_index_reg + 3'd1;
                    end
                end else begin
                    header_index_next = 3'd0;
                end
            end else if (b == nrmc_pkg::CH_CR || b == nrmc_pkg::CH_LF) begin
                in_sentence_next  = 1'b0;
                header_index_next = 3'd0;
            end else if (b == nrmc_pkg::CH_STAR) begin
                fire              = 1'b1;
                in_sentence_next  = 1'b0;
                header_index_next = 3'd0;
            end else if (b == nrmc_pkg::CH_COMMA) begin
                if (field_count_reg != nrmc_pkg::FIELD_MAX)
                    field_count_next = field_count_reg + 4'd1;
            end else if (field_count_reg == nrmc_pkg::STATUS_FIELD) begin
                if (b == nrmc_pkg::CH_A)
                    status_valid_next = 1'b1;
                else if (b == nrmc_pkg::CH_V)
                    status_valid_next = 1'b0;
            end else if (field_count_reg == nrmc_pkg::SPEED_FIELD) begin
                if (b == nrmc_pkg::CH_POINT) begin
                    seen_point_next = 1'b1;
                end else if (is_digit) begin
                    if (!seen_point_reg) begin
                        knots_milli_next = (int_sum > {4'b0, nrmc_pkg::KNOTS_MAX}) ?
                            nrmc_pkg::KNOTS_MAX : int_sum[nrmc_pkg::KNOTS_W-1:0];
                    end else if (fraction_digits_reg < FRAC_LIMIT) begin
                        knots_milli_next = (frac_sum > {1'b0, nrmc_pkg::KNOTS_MAX}) ?
                            nrmc_pkg::KNOTS_MAX : frac_sum[nrmc_pkg::KNOTS_W-1:0];
                        fraction_digits_next = fraction_digits_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        ev_next = ev_reg;
        if (fire) begin
            ev_valid_next       = 1'b1;
            ev_next.knots_milli = knots_milli_reg;
            ev_next.no_fix      = !status_valid_reg;
        end else if (ev_ready) begin
            ev_valid_next = 1'b0;
        end else begin
            ev_valid_next = ev_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            header_index_reg    <= '0;
            in_sentence_reg     <= 1'b0;
            field_count_reg     <= '0;
            status_valid_reg    <= 1'b0;
            knots_milli_reg     <= '0;
            fraction_digits_reg <= 2'd0;
            seen_point_reg      <= 1'b0;
            ev_valid_reg        <= 1'b0;
        end else begin
            header_index_reg    <= header_index_next;
            in_sentence_reg     <= in_sentence_next;
            field_count_reg     <= field_count_next;
            status_valid_reg    <= status_valid_next;
            knots_milli_reg     <= knots_milli_next;
            fraction_digits_reg <= fraction_digits_next;
            seen_point_reg      <= seen_point_next;
            ev_valid_reg        <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

endmodule

FILE: rtl/nrmc_scaler.sv
// ---------------------------------------------------------------------------
// NMEA RMC speed scaler
// Knots times Q16 scale, registered product, then rounding into the result
// register.
// ---------------------------------------------------------------------------
module nrmc_scaler
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ev_valid,
    input  nrmc_pkg::nrmc_event_t         ev,
    output logic                          ev_ready,
    input  logic [nrmc_pkg::SCALE_W-1:0]  scale,
    nrmc_speed_if.source                  speed
);

    logic                          mul_valid_reg, mul_valid_next;
    logic [nrmc_pkg::PROD_W-1:0]   mul_prod_reg;
    logic                          mul_no_fix_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [nrmc_pkg::SPEED_W-1:0]  out_speed_reg;
    logic                          out_fix_reg;

    logic                          adv_out;
    logic                          adv_mul;
    logic [nrmc_pkg::PROD_W-1:0]   rounded;

    assign adv_out  = !out_valid_reg || speed.ready;
    assign adv_mul  = !mul_valid_reg || adv_out;
    assign ev_ready = adv_mul;
    assign rounded  = mul_prod_reg + nrmc_pkg::ROUND_HALF;

    always_comb
    begin
        mul_valid_next = adv_mul ? ev_valid : mul_valid_reg;
        out_valid_next = adv_out ? mul_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_mul && ev_valid) begin
            mul_prod_reg   <= {{nrmc_pkg::SCALE_W{1'b0}}, ev.knots_milli} *
                              {{nrmc_pkg::KNOTS_W{1'b0}}, scale};
            mul_no_fix_reg <= ev.no_fix;
        end
        if (adv_out && mul_valid_reg) begin
            out_speed_reg <= mul_no_fix_reg ? '0 :
                rounded[nrmc_pkg::FRAC_SHIFT +: nrmc_pkg::SPEED_W];
            out_fix_reg   <= mul_no_fix_reg;
        end
    end

    assign speed.valid           = out_valid_reg;
    assign speed.speed_milli_mph = out_speed_reg;
    assign speed.fix_status      = out_fix_reg;

endmodule

FILE: rtl/nmea_rmc_speed_extractor.sv
// ---------------------------------------------------------------------------
// NMEA RMC speed extractor
// Parses $GPRMC sentences from a byte stream and reports speed in milli-mph.
// ---------------------------------------------------------------------------
// Usage:
//   rx    : one ASCII byte per transfer. Bytes are taken one per cycle while ready.
//   speed : one transfer per sentence that a '*' closes; speed in
//           thousandths of mph and fix_status (1 = no fix, speed then zero).
//   cfg_wr_en / cfg_wr_data : Q16 knots-to-mph scale, written while idle.
// Path: the '*' transfer loads the event register, then the product register,
//   then the result register, which offers the result.
//   Throughput: 1 byte per cycle while rx.ready is high.
// Stall: the three registers form a short queue; rx stays ready while any
//   stage is free, so up to three results may be pending before rx.ready
//   drops. Back-to-back '*' bytes are taken at full rate.
// Reset: parser back to hunting for '$', no pending result, scale 75417.
// ---------------------------------------------------------------------------
module nmea_rmc_speed_extractor
#(
    parameter int FRACTION_DIGITS = nrmc_pkg::FRACTION_DIGITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    nrmc_byte_if.sink                     rx,
    nrmc_speed_if.source                  speed,
    input  logic                          cfg_wr_en,
    input  logic [nrmc_pkg::SCALE_W-1:0]  cfg_wr_data
);

    logic [nrmc_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic                         ev_valid;
    logic                         ev_ready;
    nrmc_pkg::nrmc_event_t        ev;

    assign scale_next = cfg_wr_en ? cfg_wr_data : scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= nrmc_pkg::SCALE_RESET;
        else
            scale_reg <= scale_next;
    end

    nrmc_parser
    #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    )
    u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .ev_valid (ev_valid),
        .ev       (ev),
        .ev_ready (ev_ready)
    );

    nrmc_scaler u_scaler
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (ev_valid),
        .ev       (ev),
        .ev_ready (ev_ready),
        .scale    (scale_reg),
        .speed    (speed)
    );

endmodule

FILE: rtl/nrmc_sva.sv
// ---------------------------------------------------------------------------
// NMEA RMC speed extractor port checker
// Watches the top-level channels; bound to the top level.
// ---------------------------------------------------------------------------
`include "nmea_rmc_speed_extractor_assert.svh"

module nrmc_sva
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [nrmc_pkg::SPEED_W-1:0]  speed_milli_mph,
    input logic                          fix_status
);

    `NRMC_ASSERT_SAME(a_nofix_zero, out_valid && fix_status, speed_milli_mph == '0, "no-fix result with nonzero speed")
    `NRMC_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "rx not ready while no result is pending")
    `NRMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(speed_milli_mph) && $stable(fix_status), "stalled result changed")

endmodule

bind nmea_rmc_speed_extractor nrmc_sva u_nrmc_sva
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (rx.valid),
    .in_ready        (rx.ready),
    .out_valid       (speed.valid),
    .out_ready       (speed.ready),
    .speed_milli_mph (speed.speed_milli_mph),
    .fix_status      (speed.fix_status)
);
